@@ design/double_ended_queue_core_macros.svh @@
// Assertion macros for the double-ended queue core.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/deq_pkg.sv @@
// Shared types and constants for the double-ended queue core.
package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int FUNC_W    = 3;
	localparam int DATA_W    = 32;

	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_DUMP       = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic    load;
		logic    push_front;
		logic    push_rear;
		logic    pop_front;
		logic    pop_rear;
		logic    walk_clear;
		logic    walk_read;
		logic    emit;
		status_t emit_status;
	} deq_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              empty;
		logic              full;
		logic              walk_end;
	} deq_stat_t;

endpackage

@@ design/deq_ram.sv @@
// Generic simple dual-port RAM with registered read.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/deq_ctrl.sv @@
// Controller state machine for the double-ended queue core.
module deq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  deq_pkg::deq_stat_t stat,
	output deq_pkg::deq_cmd_t  cmd
);

	import deq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				case (stat.func)
					OP_PUSH_FRONT: begin
						cmd.emit = 1'b1;
						if (stat.full) begin
							cmd.emit_status = ST_OVERFLOW;
						end else begin
							cmd.emit_status = ST_OK;
							cmd.push_front  = 1'b1;
						end
					end
					OP_PUSH_REAR: begin
						cmd.emit = 1'b1;
						if (stat.full) begin
							cmd.emit_status = ST_OVERFLOW;
						end else begin
							cmd.emit_status = ST_OK;
							cmd.push_rear   = 1'b1;
						end
					end
					OP_POP_FRONT: begin
						if (stat.empty) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_UNDERFLOW;
						end else begin
							cmd.pop_front = 1'b1;
							state_d       = S_DRAIN;
						end
					end
					OP_POP_REAR: begin
						if (stat.empty) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_UNDERFLOW;
						end else begin
							cmd.pop_rear = 1'b1;
							state_d      = S_DRAIN;
						end
					end
					OP_DUMP: begin
						if (stat.empty) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_EMPTY;
						end else begin
							cmd.walk_clear = 1'b1;
							state_d        = S_WALK;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_WALK: begin
				cmd.walk_read = 1'b1;
				if (stat.walk_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ design/deq_dp.sv @@
// Datapath for the double-ended queue core: indices, store and result register.
module deq_dp #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [deq_pkg::FUNC_W-1:0]         func,
	input  logic signed [deq_pkg::DATA_W-1:0]  value,
	input  deq_pkg::deq_cmd_t                  cmd,
	output deq_pkg::deq_stat_t                 stat,
	output logic                               valid,
	output deq_pkg::status_t                   status,
	output logic signed [deq_pkg::DATA_W-1:0]  data,
	output logic                               last
);

	import deq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

	logic [FUNC_W-1:0]        func_q;
	logic signed [DATA_W-1:0] value_q;
	logic [IDX_W-1:0]         head_q;
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         walk_q;
	logic                     rd_valid_s1;
	logic                     rd_last_s1;
	logic                     res_valid_q;
	status_t                  res_status_q;
	logic signed [DATA_W-1:0] res_data_q;
	logic                     res_last_q;

	logic [CNT_W-1:0] count_dec;
	logic [CNT_W-1:0] walk_next;
	logic [IDX_W-1:0] offset;
	logic [IDX_W:0]   slot_sum;
	logic [IDX_W-1:0] slot_idx;
	logic [IDX_W-1:0] head_dec;
	logic             walk_end;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	assign count_dec = count_q - CNT_W'(1);
	assign walk_next = CNT_W'(walk_q) + CNT_W'(1);
	assign walk_end  = (walk_next == count_q);
	assign head_dec  = (head_q == '0) ? IDX_LAST : head_q - IDX_W'(1);

	always_comb begin
		if (cmd.pop_front) begin
			offset = IDX_W'(1);
		end else if (cmd.pop_rear) begin
			offset = count_dec[IDX_W-1:0];
		end else if (cmd.push_rear) begin
			offset = count_q[IDX_W-1:0];
		end else begin
			offset = walk_q;
		end
	end

	// head + offset, wrapped once into the store
	assign slot_sum = {1'b0, head_q} + {1'b0, offset};
	assign slot_idx = (slot_sum >= DEPTH_X) ? IDX_W'(slot_sum - DEPTH_X) : slot_sum[IDX_W-1:0];

	assign ram_we    = cmd.push_front | cmd.push_rear;
	assign ram_waddr = cmd.push_front ? head_dec : slot_idx;
	assign ram_re    = cmd.pop_front | cmd.pop_rear | cmd.walk_read;
	assign ram_raddr = cmd.pop_front ? head_q : slot_idx;

	deq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			walk_q      <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.push_front) begin
				head_q <= head_dec;
			end else if (cmd.pop_front) begin
				head_q <= slot_idx;
			end
			if (ram_we) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop_front | cmd.pop_rear) begin
				count_q <= count_dec;
			end
			if (cmd.walk_clear) begin
				walk_q <= '0;
			end else if (cmd.walk_read) begin
				walk_q <= walk_q + IDX_W'(1);
			end
			rd_valid_s1 <= ram_re;
			rd_last_s1  <= cmd.pop_front | cmd.pop_rear | (cmd.walk_read & walk_end);
			res_valid_q <= rd_valid_s1 | cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			res_status_q <= ST_OK;
			res_data_q   <= ram_rdata;
			res_last_q   <= rd_last_s1;
		end else if (cmd.emit) begin
			res_status_q <= cmd.emit_status;
			res_data_q   <= '0;
			res_last_q   <= 1'b1;
		end
	end

	assign stat.func     = func_q;
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CNT_FULL);
	assign stat.walk_end = walk_end;

	assign valid  = res_valid_q;
	assign status = res_status_q;
	assign data   = res_data_q;
	assign last   = res_last_q;

endmodule

@@ design/double_ended_queue_core.sv @@
// Top level of the double-ended queue core: controller, datapath and checks.
//
// Bounded double-ended queue of DEPTH signed 32-bit words in a circular store.
// Command channel: func and value are taken at a rising edge with start high
// and busy low. func selects push front, push rear, pop front, pop rear or dump;
// other codes are dropped without a result.
// Result channel: valid marks status, data and last for exactly one cycle.
// The receiver cannot stall; every result must be taken when shown.
// States from the accepting edge to the next possible accept:
//   push, and any refused or empty operation: execute, then back to idle
//   pop: execute, then drain (one registered store read)
//   dump: execute, walk (one store read per word), drain; results back to back
// The single store read port sets the dump rate. The result appears in the
// same cycle that busy falls and may overlap the next accept.
// Reset clears head index, entry count and the controller; the store contents
// are not cleared and are never read before written.
`include "double_ended_queue_core_macros.svh"

module double_ended_queue_core #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [deq_pkg::FUNC_W-1:0]        func,
	input  logic signed [deq_pkg::DATA_W-1:0] value,
	output logic                              valid,
	output deq_pkg::status_t                  status,
	output logic signed [deq_pkg::DATA_W-1:0] data,
	output logic                              last
);

	import deq_pkg::*;

	deq_cmd_t  cmd;
	deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	deq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.func  (func),
		.value (value),
		.cmd   (cmd),
		.stat  (stat),
		.valid (valid),
		.status(status),
		.data  (data),
		.last  (last)
	);

	`DEQ_ASSERT_NEXT(a_dump_back_to_back, valid && !last, valid, "dump transfer gap")
	`DEQ_ASSERT_NEXT(a_no_result_after_accept, start && !busy, !valid, "result right after accept")
	`DEQ_ASSERT_NOW(a_error_is_last, valid && (status != ST_OK), last && (data == '0),
		"error result not final or data nonzero")

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the double-ended queue core: directed and random transfers.
`timescale 1ns / 1ps

module tb_top;
	import deq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 90;
	localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;
	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIXED
	} mix_mode_t;

	typedef struct packed {
		status_t                    status;
		logic signed [DATA_W-1:0]   data;
		logic                       last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [FUNC_W-1:0] func = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic busy;
	logic valid;
	status_t status;
	logic signed [DATA_W-1:0] data;
	logic last;

	logic signed [DATA_W-1:0] deque_words[$];
	result_t awaited_results[$];
	int mismatches = 0;

	double_ended_queue_core #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.value(value),
		.valid(valid),
		.status(status),
		.data(data),
		.last(last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("double_ended_queue_core regression: fail");
		$finish;
	end

	// Expected results of one accepted transfer.
	task automatic deque_apply(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
		int n;
		n = deque_words.size();
		case (f)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (n >= DEPTH) begin
					awaited_results.push_back(result_t'{ST_OVERFLOW, 32'sd0, 1'b1});
				end else begin
					if (f == OP_PUSH_FRONT)
						deque_words.push_front(v);
					else
						deque_words.push_back(v);
					awaited_results.push_back(result_t'{ST_OK, 32'sd0, 1'b1});
				end
			end
			OP_POP_FRONT: begin
				if (n == 0)
					awaited_results.push_back(result_t'{ST_UNDERFLOW, 32'sd0, 1'b1});
				else
					awaited_results.push_back(result_t'{ST_OK, deque_words.pop_front(), 1'b1});
			end
			OP_POP_REAR: begin
				if (n == 0)
					awaited_results.push_back(result_t'{ST_UNDERFLOW, 32'sd0, 1'b1});
				else
					awaited_results.push_back(result_t'{ST_OK, deque_words.pop_back(), 1'b1});
			end
			OP_DUMP: begin
				if (n == 0) begin
					awaited_results.push_back(result_t'{ST_EMPTY, 32'sd0, 1'b1});
				end else begin
					for (int i = 0; i < n; i++)
						awaited_results.push_back(result_t'{ST_OK, deque_words[i], i == n - 1});
				end
			end
			default: ;
		endcase
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(3, 1);
		else
			return $urandom_range(40, 5);
	endfunction

	// Called just after a rising edge; returns just after the edge that follows the gap.
	task automatic send_transfer(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v,
			input int gap);
		start <= 1'b1;
		func <= f;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		deque_apply(f, v);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_queue();
		send_transfer(OP_POP_FRONT, $urandom, pick_gap());
		send_transfer(OP_POP_REAR, $urandom, pick_gap());
		send_transfer(OP_DUMP, $urandom, 0);
		send_transfer(FUNC_RSVD5, $urandom, pick_gap());
		send_transfer(FUNC_RSVD6, $urandom, 0);
		send_transfer(FUNC_RSVD7, $urandom, pick_gap());
	endtask

	task automatic test_fill_and_overflow();
		send_transfer(OP_PUSH_FRONT, WORD_MIN, pick_gap());
		send_transfer(OP_PUSH_REAR, WORD_MAX, 0);
		send_transfer(OP_PUSH_FRONT, 32'sd0, pick_gap());
		send_transfer(OP_PUSH_REAR, -32'sd1, pick_gap());
		for (int i = 4; i < DEPTH; i++)
			send_transfer(i[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, $urandom, pick_gap());
		send_transfer(OP_PUSH_FRONT, $urandom, 0);
		send_transfer(OP_PUSH_REAR, $urandom, pick_gap());
		send_transfer(OP_DUMP, $urandom, 0);
	endtask

	task automatic test_pop_both_ends();
		send_transfer(OP_POP_FRONT, $urandom, 0);
		send_transfer(OP_POP_REAR, $urandom, pick_gap());
		send_transfer(OP_DUMP, $urandom, 0);
		wait_drained();
	endtask

	function automatic logic [FUNC_W-1:0] pick_func(input mix_mode_t mode);
		int r;
		int push_pct;
		r = $urandom_range(99);
		case (mode)
			MODE_FILL: push_pct = 80;
			MODE_DRAIN: push_pct = 15;
			default: push_pct = 45;
		endcase
		if (r >= 96)
			return 3'($urandom_range(7, 5));
		if (r >= 88)
			return OP_DUMP;
		if (r < push_pct)
			return $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
		return $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(19))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random_traffic();
		int sent;
		int seg_len;
		bit no_idle;
		mix_mode_t mode;
		logic [FUNC_W-1:0] f;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = mix_mode_t'($urandom_range(2));
			seg_len = $urandom_range(25, 10);
			no_idle = ($urandom_range(3) == 0);
			for (int i = 0; i < seg_len; i++) begin
				f = pick_func(mode);
				send_transfer(f, pick_word(), no_idle ? 0 : pick_gap());
				if (f <= OP_DUMP)
					sent++;
			end
			if ($urandom_range(3) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_fill_and_overflow();
		test_pop_both_ends();
		test_random_traffic();
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("double_ended_queue_core regression: pass");
		else
			$display("double_ended_queue_core regression: fail");
		$finish;
	end

	always @(posedge clk) begin : result_check
		result_t exp;
		if (arst_n && valid) begin
			if (awaited_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: status %0d data %0d last %0b",
						status, data, last);
				mismatches++;
			end else begin
				exp = awaited_results.pop_front();
				if (status !== exp.status || data !== exp.data || last !== exp.last) begin
					if (mismatches < 10)
						$display("mismatch: exp status %0d data %0d last %0b, ",
							exp.status, exp.data, exp.last,
							"got status %0d data %0d last %0b", status, data, last);
					mismatches++;
				end
			end
		end
	end

endmodule

@@ filelist.f @@
+incdir+design
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/deq_dp.sv
design/double_ended_queue_core.sv
bench/tb_top.sv
